/* hw/rtl/sgm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse GF(2) matrix-vector core: shared package
// Sizes, action codes and the record that the front end hands to the back end.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int unsigned VEC_LEN = 2048;
  localparam int unsigned VEC_AW  = $clog2(VEC_LEN);
  localparam int unsigned POS_W   = 11;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ENTRY = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_PASS  = 2'd3
  } act_e;

  // One classified item as it travels through the queue.
  typedef struct packed {
    act_e             op;
    logic             sub;     // substitution mode was active
    logic [ROW_W-1:0] row;
    logic [POS_W-1:0] pos;
    logic             bitv;
    logic             last;
    logic             col_ok;  // column (or load position) is usable
    logic             row_ok;  // row lies inside the vector
  } item_t;

endpackage

/* hw/rtl/sgm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse GF(2) matrix-vector core: front end
// Holds the mode register and the row counter, and classifies every accepted
// item so that the back end only has to read memory and accumulate.
// ----------------------------------------------------------------------------
module sgm_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                accept_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [sgm_pkg::POS_W-1:0] position_i,
  input  wire logic                bit_value_i,
  input  wire logic                close_row_i,
  output sgm_pkg::item_t           item_o
);

  logic                        mode_q, mode_d;
  logic [sgm_pkg::ROW_W-1:0]   row_q, row_d;
  sgm_pkg::act_e               act;
  logic                        pos_in_vec;
  logic                        pos_below_row;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_q} : 32'd0;

  assign act           = sgm_pkg::act_e'(action_i);
  assign pos_in_vec    = 32'(position_i) < sgm_pkg::VEC_LEN;
  assign pos_below_row = {1'b0, position_i} < row_q;

  always_comb begin
    item_o.op     = act;
    item_o.sub    = mode_q;
    item_o.row    = row_q;
    item_o.pos    = position_i;
    item_o.bitv   = bit_value_i;
    item_o.last   = close_row_i;
    item_o.row_ok = 32'(row_q) < sgm_pkg::VEC_LEN;
    item_o.col_ok = mode_q && (act == sgm_pkg::ACT_ENTRY) ?
                    (pos_in_vec && pos_below_row) : pos_in_vec;
  end

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      mode_d = pwdata[0];
    end
    row_d = row_q;
    if (accept_i) begin
      case (act)
        sgm_pkg::ACT_ENTRY: if (close_row_i) row_d = row_q + 1'b1;
        sgm_pkg::ACT_CLOSE: row_d = row_q + 1'b1;
        sgm_pkg::ACT_PASS:  row_d = '0;
        default:            row_d = row_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      row_q  <= '0;
    end else begin
      mode_q <= mode_d;
      row_q  <= row_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sgm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse GF(2) matrix-vector core: item queue
// A short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module sgm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sgm_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                nonempty_o,
  output sgm_pkg::item_t      item_o
);

  sgm_pkg::item_t               slot_q [sgm_pkg::Q_DEPTH];
  logic [sgm_pkg::Q_AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [sgm_pkg::Q_CW-1:0]     cnt_q, cnt_d;

  assign full_o     = cnt_q == sgm_pkg::Q_CW'(sgm_pkg::Q_DEPTH);
  assign nonempty_o = cnt_q != '0;
  assign item_o     = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + sgm_pkg::Q_CW'(push_i) - sgm_pkg::Q_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !nonempty_o)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sgm_pkg::Q_CW'(sgm_pkg::Q_DEPTH)) else $error("queue count out of range");
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |=> rd_q == $past(rd_q) + 1'b1) else $error("read pointer did not advance");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sgm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse GF(2) matrix-vector core: back end
// Holds the vector and solved-bit memories, reads one bit of each per item and
// accumulates the row parity; a closing item produces the row's result.
// ----------------------------------------------------------------------------
module sgm_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      head_valid_i,
  input  wire sgm_pkg::item_t            head_i,
  output logic                           pop_o,
  output logic                           result_valid_o,
  output logic [sgm_pkg::POS_W-1:0]      row_index_o,
  output logic                           parity_bit_o,
  output logic                           index_fault_o
);

  logic                      input_mem [sgm_pkg::VEC_LEN];
  logic                      solved_mem [sgm_pkg::VEC_LEN];

  logic [sgm_pkg::VEC_AW-1:0] in_raddr, sb_raddr, in_waddr, sb_waddr;
  logic                       in_we, sb_we, sb_wdata;
  logic                       in_rd_q, sb_rd_q;
  logic                       fwd_hit_q, fwd_bit_q;

  logic                       b_vld_q;
  sgm_pkg::item_t             b_q;
  logic                       par_q, par_d, flt_q, flt_d;
  logic                       sbit, term, par_acc, flt_acc, closing;
  logic                       res_bit, res_flt;
  logic                       res_vld_q;
  logic [sgm_pkg::POS_W-1:0]  res_row_q;
  logic                       res_bit_q, res_flt_q;

  assign pop_o = head_valid_i;

  // Read issue: multiply entries read the vector at the column; otherwise
  // the vector is read at the row for the closing term of substitution.
  assign sb_raddr = sgm_pkg::VEC_AW'(head_i.pos);
  assign in_raddr = (head_i.op == sgm_pkg::ACT_ENTRY && !head_i.sub) ?
                    sgm_pkg::VEC_AW'(head_i.pos) : sgm_pkg::VEC_AW'(head_i.row);
  assign in_we    = head_valid_i && head_i.op == sgm_pkg::ACT_LOAD && head_i.col_ok;
  assign in_waddr = sgm_pkg::VEC_AW'(head_i.pos);

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      input_mem[in_waddr] <= head_i.bitv;
    end
    in_rd_q <= input_mem[in_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sb_we) begin
      solved_mem[sb_waddr] <= sb_wdata;
    end
    sb_rd_q <= solved_mem[sb_raddr];
    // A bit solved in the same cycle as its read is taken from the bypass.
    fwd_hit_q <= sb_we && (sb_waddr == sb_raddr);
    fwd_bit_q <= sb_wdata;
  end

  always_comb begin
    sbit    = fwd_hit_q ? fwd_bit_q : sb_rd_q;
    term    = (b_q.op == sgm_pkg::ACT_ENTRY && b_q.col_ok) ?
              (b_q.sub ? sbit : in_rd_q) : 1'b0;
    par_acc = par_q ^ term;
    flt_acc = flt_q | (b_q.op == sgm_pkg::ACT_ENTRY && !b_q.col_ok);
    closing = b_vld_q && (b_q.op == sgm_pkg::ACT_CLOSE ||
                          (b_q.op == sgm_pkg::ACT_ENTRY && b_q.last));
    res_bit = par_acc ^ (b_q.sub && b_q.row_ok && in_rd_q);
    res_flt = flt_acc | (b_q.sub && !b_q.row_ok);

    sb_we    = closing && b_q.sub && b_q.row_ok;
    sb_waddr = sgm_pkg::VEC_AW'(b_q.row);
    sb_wdata = res_bit;

    par_d = par_q;
    flt_d = flt_q;
    if (b_vld_q) begin
      if (closing || b_q.op == sgm_pkg::ACT_PASS) begin
        par_d = 1'b0;
        flt_d = 1'b0;
      end else if (b_q.op == sgm_pkg::ACT_ENTRY) begin
        par_d = par_acc;
        flt_d = flt_acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      par_q     <= 1'b0;
      flt_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      b_vld_q   <= head_valid_i;
      par_q     <= par_d;
      flt_q     <= flt_d;
      res_vld_q <= closing;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q       <= head_i;
    res_row_q <= b_q.row[sgm_pkg::POS_W-1:0];
    res_bit_q <= res_bit;
    res_flt_q <= res_flt;
  end

  assign result_valid_o = res_vld_q;
  assign row_index_o    = res_row_q;
  assign parity_bit_o   = res_bit_q;
  assign index_fault_o  = res_flt_q;

`ifndef SYNTHESIS
  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(b_vld_q)) else $error("result without a closing item");
  a_solved_write_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_we |-> (b_q.sub && b_q.row_ok)) else $error("solved bit written outside substitution");
  a_row_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closing && b_q.sub && !b_q.row_ok |=> res_flt_q) else $error("row beyond vector not flagged");
  a_parity_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closing |=> !par_q && !flt_q) else $error("row state not cleared after close");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sparse_gf2_matvec_and_substitution_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse GF(2) matrix-vector multiply and forward substitution core
// Loads a bit vector, then multiplies a sparse binary matrix given row-wise as
// column lists by it, or solves a strictly lower-triangular system row by row.
// ----------------------------------------------------------------------------
//
//   channel   handshake                      payload
//   config    psel/penable/pwrite, pready    paddr, pwdata, prdata (mode)
//   item in   start high, busy low           action_i, position_i,
//                                            bit_value_i, close_row_i
//   result    result_valid_o, one cycle      row_index_o, parity_bit_o,
//                                            index_fault_o
//
// One item is taken per cycle; a closing item's result passes through the
// queue slot, the memory read and the output register to the result ports.
// Each item reads one bit of the vector and one of the solved-bit memory;
// a solved bit written in the cycle it is read is bypassed.
// The back end takes the queue head every cycle, so the queue never holds
// more than one item and busy stays low.
// Reset clears the mode, the row counter and the row parity; the memories
// hold no reset value. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module sparse_gf2_matvec_and_substitution_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    action_i,
  input  wire logic [sgm_pkg::POS_W-1:0]     position_i,
  input  wire logic                          bit_value_i,
  input  wire logic                          close_row_i,
  output logic                               result_valid_o,
  output logic [sgm_pkg::POS_W-1:0]          row_index_o,
  output logic                               parity_bit_o,
  output logic                               index_fault_o
);

  logic           accept;
  logic           q_full, q_nonempty, pop;
  sgm_pkg::item_t front_item, head_item;

  assign busy   = q_full;
  assign accept = start && !q_full;

  sgm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .accept_i    (accept),
    .action_i    (action_i),
    .position_i  (position_i),
    .bit_value_i (bit_value_i),
    .close_row_i (close_row_i),
    .item_o      (front_item)
  );

  sgm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .item_i     (front_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .nonempty_o (q_nonempty),
    .item_o     (head_item)
  );

  sgm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_nonempty),
    .head_i         (head_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .row_index_o    (row_index_o),
    .parity_bit_o   (parity_bit_o),
    .index_fault_o  (index_fault_o)
  );

endmodule
`default_nettype wire
